@@ rtl/fpdda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdda_pkg - shared constants for the fixed-point DDA line stepper
// Fixed-point scale, input modes, default coordinate width and queue depth.
// ----------------------------------------------------------------------------
package fpdda_pkg;

    // coordinate width at the ports, default
    localparam int COORD_BITS_DEF = 12;

    // fraction bits of the accumulator (scale 8192)
    localparam int DDA_SHIFT = 13;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

endpackage

@@ rtl/fpdda_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdda_if - valid/ready channels of the line stepper
// Command channel (start or step beats) and pixel channel (point beats).
// ----------------------------------------------------------------------------
interface fpdda_in_if #(
    parameter int COORD_BITS = fpdda_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, mode, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, mode, start_x, start_y, end_x, end_y, output ready);
endinterface

interface fpdda_out_if #(
    parameter int COORD_BITS = fpdda_pkg::COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last;

    modport source (output valid, point_x, point_y, last, input ready);
    modport sink   (input valid, point_x, point_y, last, output ready);
endinterface

@@ rtl/fpdda_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdda_front - command intake and line setup
// Step beats pass straight to the queue. Start beats pick the major axis and
// run a radix-2 restoring divider for the slope, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fpdda_front #(
    parameter int  COORD_BITS = fpdda_pkg::COORD_BITS_DEF,
    parameter type t_cmd      = logic
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpdda_in_if.sink  i_cmd,
    output logic      o_push,
    output t_cmd      o_push_data,
    input  logic      i_full
);
    import fpdda_pkg::*;

    localparam int QB       = DDA_SHIFT + 1;          // quotient bits, |slope| <= 8192
    localparam int CW       = $clog2(QB);
    localparam int ACC_BITS = COORD_BITS + DDA_SHIFT + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} t_state;

    t_state                r_state;
    logic [CW-1:0]         r_cnt;
    logic [COORD_BITS:0]   r_rem;
    logic [QB-1:0]         r_quo;
    logic [COORD_BITS-1:0] r_span;
    logic                  r_neg;
    t_cmd                  r_cmd;

    logic [COORD_BITS-1:0] adx, ady, ms, me, ns, ne, span, dmag;
    logic                  maj_x, neg, accept, ge;
    logic [COORD_BITS:0]   rem_sub;
    logic [ACC_BITS-1:0]   mag, slope;

    assign i_cmd.ready = (r_state == ST_IDLE) && !i_full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // endpoint classification
    always_comb begin
        adx   = (i_cmd.end_x >= i_cmd.start_x) ? i_cmd.end_x - i_cmd.start_x
                                               : i_cmd.start_x - i_cmd.end_x;
        ady   = (i_cmd.end_y >= i_cmd.start_y) ? i_cmd.end_y - i_cmd.start_y
                                               : i_cmd.start_y - i_cmd.end_y;
        maj_x = adx > ady;
        ms    = maj_x ? i_cmd.start_x : i_cmd.start_y;
        me    = maj_x ? i_cmd.end_x   : i_cmd.end_y;
        ns    = maj_x ? i_cmd.start_y : i_cmd.start_x;
        ne    = maj_x ? i_cmd.end_y   : i_cmd.end_x;
        span  = maj_x ? adx : ady;
        neg   = ne < ns;
        dmag  = neg ? ns - ne : ne - ns;
    end

    // one divider step: remainder stays below the span
    assign ge      = (r_span != '0) && (r_rem >= {1'b0, r_span});
    assign rem_sub = ge ? r_rem - {1'b0, r_span} : r_rem;

    // slope, truncated toward zero
    assign mag   = {{(ACC_BITS-QB){1'b0}}, r_quo};
    assign slope = r_neg ? -mag : mag;

    // queue write
    always_comb begin
        o_push_data = r_cmd;
        if (r_state == ST_PUSH) begin
            o_push              = !i_full;
            o_push_data.slope   = slope;
        end else begin
            o_push              = accept && (i_cmd.mode == MODE_STEP);
            o_push_data.is_start = 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && (i_cmd.mode == MODE_START)) begin
                        r_state              <= ST_DIV;
                        r_cnt                <= CW'(QB - 1);
                        r_rem                <= {1'b0, dmag};
                        r_span               <= span;
                        r_neg                <= neg;
                        r_cmd.is_start       <= 1'b1;
                        r_cmd.major_is_x     <= maj_x;
                        r_cmd.dir_neg        <= me < ms;
                        r_cmd.major_start    <= ms;
                        r_cmd.major_end      <= me;
                        r_cmd.minor_start    <= ns;
                        r_cmd.slope          <= '0;
                    end
                end
                ST_DIV: begin
                    r_quo <= {r_quo[QB-2:0], ge};
                    r_rem <= {rem_sub[COORD_BITS-1:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/fpdda_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdda_queue - short command FIFO between setup and stepping
// Register-based, first-word fall-through.
// ----------------------------------------------------------------------------
module fpdda_queue #(
    parameter type t_cmd = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);
    import fpdda_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_count;

    assign o_full  = r_count == NW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue read while empty");

endmodule

@@ rtl/fpdda_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpdda_back - DDA stepping engine and pixel output register
// Loads line state from start commands; each step emits the corner pixel
// (when the minor coordinate moved) and then the current pixel.
// ----------------------------------------------------------------------------
module fpdda_back #(
    parameter int  COORD_BITS = fpdda_pkg::COORD_BITS_DEF,
    parameter type t_cmd      = logic
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cmd        i_data,
    output logic        o_pop,
    fpdda_out_if.source o_pix
);
    import fpdda_pkg::*;

    localparam int ACC_BITS = COORD_BITS + DDA_SHIFT + 1;

    logic                  r_active;
    logic                  r_major_is_x;
    logic                  r_dir_neg;
    logic [COORD_BITS-1:0] r_major_pos;
    logic [COORD_BITS-1:0] r_major_end;
    logic [COORD_BITS-1:0] r_minor_pos;
    logic [COORD_BITS-1:0] r_minor_prev;
    logic [ACC_BITS-1:0]   r_accum;
    logic [ACC_BITS-1:0]   r_slope;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic                  r_last;

    logic                  out_free, is_step, emit, corner, at_end;
    logic [COORD_BITS-1:0] out_minor;
    logic [ACC_BITS-1:0]   accum_nx;

    assign out_free  = !r_out_valid || o_pix.ready;
    assign is_step   = i_valid && !i_data.is_start;
    assign corner    = r_minor_pos != r_minor_prev;
    assign at_end    = r_major_pos == r_major_end;
    assign emit      = is_step && r_active && out_free;
    assign out_minor = corner ? r_minor_prev : r_minor_pos;
    assign accum_nx  = r_accum + r_slope;

    // a step leaves the queue once its last pixel is out; idle steps drop
    assign o_pop = i_valid && (i_data.is_start || !r_active || (out_free && !corner));

    assign o_pix.valid   = r_out_valid;
    assign o_pix.point_x = r_px;
    assign o_pix.point_y = r_py;
    assign o_pix.last    = r_last;

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_valid && i_data.is_start) begin
            r_active     <= 1'b1;
            r_major_is_x <= i_data.major_is_x;
            r_dir_neg    <= i_data.dir_neg;
            r_major_pos  <= i_data.major_start;
            r_major_end  <= i_data.major_end;
            r_minor_pos  <= i_data.minor_start;
            r_minor_prev <= i_data.minor_start;
            r_accum      <= {1'b0, i_data.minor_start, 1'b1, {(DDA_SHIFT-1){1'b0}}};
            r_slope      <= i_data.slope;
        end else if (emit) begin
            if (corner) begin
                r_minor_prev <= r_minor_pos;
            end else if (at_end) begin
                r_active <= 1'b0;
            end else begin
                r_accum     <= accum_nx;
                r_minor_pos <= accum_nx[DDA_SHIFT +: COORD_BITS];
                r_major_pos <= r_dir_neg ? r_major_pos - 1'b1 : r_major_pos + 1'b1;
            end
        end
    end

    // pixel output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_px   <= r_major_is_x ? r_major_pos : out_minor;
            r_py   <= r_major_is_x ? out_minor : r_major_pos;
            r_last <= !corner && at_end;
        end
    end

    a_corner_settles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && corner) |=> (r_minor_prev == r_minor_pos) && r_active)
        else $error("corner pixel did not settle the minor coordinate");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !corner && at_end) |=> !r_active && r_out_valid && r_last)
        else $error("final pixel did not close the line");

endmodule

@@ rtl/fixed_point_dda_line_stepper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_dda_line_stepper_core - fixed-point DDA line rasteriser
// Walks a line one major-axis pixel per step beat, scale 8192 accumulator.
//
//  channel  dir  beat contents                         notes
//  i_cmd    in   mode, start_x, start_y, end_x, end_y  mode 0 start, 1 step
//  o_pix    out  point_x, point_y, last                last on final pixel
//
// A step beat yields one pixel per cycle while o_pix is not stalled, a corner
// pixel first when the minor coordinate moved. A start beat holds the intake
// while the serial slope divider makes one quotient bit per cycle, 14 in all.
// Synchronous active-low reset leaves the stepper idle with empty queue.
// A two-entry command queue lets intake run while the pixel side stalls.
// ----------------------------------------------------------------------------
module fixed_point_dda_line_stepper_core #(
    parameter int COORD_BITS = fpdda_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpdda_in_if.sink    i_cmd,
    fpdda_out_if.source o_pix
);
    import fpdda_pkg::*;

    localparam int ACC_BITS = COORD_BITS + DDA_SHIFT + 1;

    typedef struct packed {
        logic                  is_start;
        logic                  major_is_x;
        logic                  dir_neg;
        logic [COORD_BITS-1:0] major_start;
        logic [COORD_BITS-1:0] major_end;
        logic [COORD_BITS-1:0] minor_start;
        logic [ACC_BITS-1:0]   slope;
    } t_cmd;

    logic push, full, q_valid, pop;
    t_cmd push_data, q_data;

    // setup and slope division
    fpdda_front #(
        .COORD_BITS (COORD_BITS),
        .t_cmd      (t_cmd)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    // decoupling queue
    fpdda_queue #(
        .t_cmd (t_cmd)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .o_valid     (q_valid),
        .o_data      (q_data),
        .i_pop       (pop)
    );

    // stepping engine
    fpdda_back #(
        .COORD_BITS (COORD_BITS),
        .t_cmd      (t_cmd)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_data  (q_data),
        .o_pop   (pop),
        .o_pix   (o_pix)
    );

endmodule
